// ===== hw/rtl/sgfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and glyph tables for the scaled glyph framebuffer drawer.
// No dependencies.

package sgfd_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 32;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } glyph_sel_t;

  function automatic glyph_sel_t glyph_lookup(input logic [7:0] code);
    glyph_sel_t s;
    s.found = 1'b1;
    s.idx   = 5'd0;
    case (code)
      8'h30: s.idx = 5'd0;
      8'h31: s.idx = 5'd1;
      8'h32: s.idx = 5'd2;
      8'h33: s.idx = 5'd3;
      8'h34: s.idx = 5'd4;
      8'h35: s.idx = 5'd5;
      8'h36: s.idx = 5'd6;
      8'h37: s.idx = 5'd7;
      8'h38: s.idx = 5'd8;
      8'h39: s.idx = 5'd9;
      8'h2d: s.idx = 5'd10;
      8'h2e: s.idx = 5'd11;
      8'h43: s.idx = 5'd12;
      8'h61: s.idx = 5'd13;
      8'h65: s.idx = 5'd14;
      8'h6d: s.idx = 5'd15;
      8'h70: s.idx = 5'd16;
      8'h72: s.idx = 5'd17;
      8'h74: s.idx = 5'd18;
      8'h75: s.idx = 5'd19;
      default: s.found = 1'b0;
    endcase
    return s;
  endfunction

  // Columns are packed with column 0 in the top byte.
  function automatic logic [6:0] glyph_col(input logic [4:0] idx, input logic [2:0] col);
    logic [39:0] row;
    logic [7:0]  b;
    case (idx)
      5'd0:  row = 40'h3e_51_49_45_3e;
      5'd1:  row = 40'h00_42_7f_40_00;
      5'd2:  row = 40'h42_61_51_49_46;
      5'd3:  row = 40'h21_41_45_4b_31;
      5'd4:  row = 40'h18_14_12_7f_10;
      5'd5:  row = 40'h27_45_45_45_39;
      5'd6:  row = 40'h3c_4a_49_49_30;
      5'd7:  row = 40'h01_71_09_05_03;
      5'd8:  row = 40'h36_49_49_49_36;
      5'd9:  row = 40'h06_49_49_29_1e;
      5'd10: row = 40'h08_08_08_08_08;
      5'd11: row = 40'h00_60_60_00_00;
      5'd12: row = 40'h3e_41_41_41_22;
      5'd13: row = 40'h20_54_54_54_78;
      5'd14: row = 40'h38_54_54_54_18;
      5'd15: row = 40'h7c_04_18_04_78;
      5'd16: row = 40'h7c_14_14_14_08;
      5'd17: row = 40'h7c_08_04_04_08;
      5'd18: row = 40'h04_3f_44_40_20;
      5'd19: row = 40'h3c_40_40_20_7c;
      default: row = 40'h0;
    endcase
    case (col)
      3'd0: b = row[39:32];
      3'd1: b = row[31:24];
      3'd2: b = row[23:16];
      3'd3: b = row[15:8];
      3'd4: b = row[7:0];
      default: b = 8'h00;
    endcase
    return b[6:0];
  endfunction

  // Glyph row of a scaled offset: the number of whole scale steps below it.
  function automatic logic [2:0] row_of(input logic [6:0] d, input logic [2:0] sc);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 1; k < 7; k++) begin
      if (d >= 7'(k) * {4'd0, sc}) begin
        r = r + 3'd1;
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/sgfd_store.sv =====
`timescale 1ns / 1ps
// Framebuffer memory: one write port and one read port with registered read data.
// No dependencies.

module sgfd_store #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/sgfd_mask.sv =====
`timescale 1ns / 1ps
// Builds the pixel mask of one framebuffer byte from one scaled glyph column.
// Depends on sgfd_pkg.

module sgfd_mask #(
  parameter int DISPLAY_HEIGHT = sgfd_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic [6:0] col_bits,
  input  logic [3:0] page,
  input  logic [4:0] y0,
  input  logic [2:0] sc,
  output logic [7:0] mask
);

  localparam logic [6:0] HEIGHT7 = 7'(DISPLAY_HEIGHT);

  logic [6:0] span;

  assign span = {4'd0, sc} * 7'd7;

  always_comb begin
    logic [6:0] y;
    logic [6:0] d;
    logic [2:0] r;
    mask = 8'h00;
    for (int b = 0; b < 8; b++) begin
      y = {page, 3'(b)};
      d = y - {2'b00, y0};
      r = sgfd_pkg::row_of(d, sc);
      if (y >= {2'b00, y0} && d < span && y < HEIGHT7) begin
        mask[b] = col_bits[r];
      end
    end
  end

endmodule

// ===== hw/rtl/scaled_glyph_framebuffer_drawer.sv =====
`timescale 1ns / 1ps
// Top level of the scaled glyph framebuffer drawer: sequencer and stream ports.
// Depends on sgfd_pkg, sgfd_store and sgfd_mask.

// After reset the block sweeps the framebuffer to zero, DISPLAY_WIDTH times
// ceil(DISPLAY_HEIGHT/8) bytes (512 by default), and holds in_tready low meanwhile.
// Every word yields one result word. A clear runs that same sweep before its result.
// A read returns the registered memory read data. A draw writes columns times pages
// bytes, where columns is five times the scale cut at the right edge and pages is
// the one to four pages the cell covers; the read-modify-write of each byte is
// pipelined through the single memory, one byte a cycle.

module scaled_glyph_framebuffer_drawer #(
  parameter int DISPLAY_WIDTH  = sgfd_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = sgfd_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[6:0], pos_y[11:7], char_code[19:12], scale[22:20], byte_index[31:23]
  input  logic [31:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0]
  output logic [7:0]  out_tdata
);

  localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [3:0]  PG_MAX  = 4'(PAGE_COUNT - 1);
  localparam logic [8:0]  WIDTH9  = 9'(DISPLAY_WIDTH);
  localparam logic [11:0] WIDTH12 = 12'(DISPLAY_WIDTH);
  localparam logic [11:0] BYTES12 = 12'(STORE_BYTES);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DRAW   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [1:0] in_op;
  logic [6:0] in_x;
  logic [4:0] in_y;
  logic [7:0] in_code;
  logic [2:0] in_sc;
  logic [8:0] in_idx;

  assign in_op   = in_tuser[1:0];
  assign in_x    = in_tdata[6:0];
  assign in_y    = in_tdata[11:7];
  assign in_code = in_tdata[19:12];
  assign in_sc   = in_tdata[22:20];
  assign in_idx  = in_tdata[31:23];

  logic [2:0]        state_r, state_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [8:0]        px_r, px_nxt;
  logic [2:0]        col_r, col_nxt;
  logic [2:0]        dx_r, dx_nxt;
  logic [3:0]        page_r, page_nxt;
  logic [3:0]        pg_first_r, pg_first_nxt;
  logic [3:0]        pg_last_r, pg_last_nxt;
  logic [4:0]        y0_r, y0_nxt;
  logic [2:0]        sc_r, sc_nxt;
  logic [4:0]        gidx_r, gidx_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [7:0]        res_r, res_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [7:0]        wr_mask_r, wr_mask_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  logic              accept;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] draw_addr;
  logic [ADDR_W-1:0] idx_addr;
  logic [11:0]       draw_addr12;
  logic [11:0]       idx12;
  logic              idx_ok;
  logic [6:0]        col_bits;
  logic [7:0]        mask;
  sgfd_pkg::glyph_sel_t gsel;
  logic [6:0]        end_y;
  logic [3:0]        in_pg_first;
  logic [3:0]        in_pg_last;
  logic              draw_go;
  logic              last_col;
  logic              slot_free;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_tready;

  assign gsel        = sgfd_pkg::glyph_lookup(in_code);
  assign end_y       = {2'b00, in_y} + {4'd0, in_sc} * 7'd7 - 7'd1;
  assign in_pg_first = {2'b00, in_y[4:3]};
  assign in_pg_last  = (end_y[6:3] > PG_MAX) ? PG_MAX : end_y[6:3];
  assign draw_go     = gsel.found && (in_sc != 3'd0) && ({2'b00, in_x} < WIDTH9) &&
                       (in_pg_first <= PG_MAX);

  assign idx12    = {3'b000, in_idx};
  assign idx_ok   = idx12 < BYTES12;
  assign idx_addr = idx12[ADDR_W-1:0];

  assign draw_addr12 = {3'b000, px_r} + {8'd0, page_r} * WIDTH12;
  assign draw_addr   = draw_addr12[ADDR_W-1:0];

  assign col_bits = sgfd_pkg::glyph_col(gidx_r, col_r);
  assign last_col = ((col_r == 3'd4) && (dx_r == sc_r - 3'd1)) ||
                    (px_r + 9'd1 >= WIDTH9);

  sgfd_mask #(
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) u_mask (
    .col_bits(col_bits),
    .page    (page_r),
    .y0      (y0_r),
    .sc      (sc_r),
    .mask    (mask)
  );

  assign rd_en   = (state_r == S_DRAW) ||
                   (accept && (in_op == sgfd_pkg::OP_READ) && idx_ok);
  assign rd_addr = (state_r == S_DRAW) ? draw_addr : idx_addr;
  assign wr_en   = (state_r == S_CLEAR) || wr_pend_r;
  assign wr_addr = (state_r == S_CLEAR) ? clr_cnt_r : wr_addr_r;
  assign wr_data = (state_r == S_CLEAR) ? 8'h00 : (rd_data | wr_mask_r);

  sgfd_store #(
    .DEPTH (STORE_BYTES),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    clr_cnt_nxt   = clr_cnt_r;
    px_nxt        = px_r;
    col_nxt       = col_r;
    dx_nxt        = dx_r;
    page_nxt      = page_r;
    pg_first_nxt  = pg_first_r;
    pg_last_nxt   = pg_last_r;
    y0_nxt        = y0_r;
    sc_nxt        = sc_r;
    gidx_nxt      = gidx_r;
    rd_ok_nxt     = rd_ok_r;
    res_nxt       = res_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    wr_mask_nxt   = wr_mask_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          clr_cnt_nxt = '0;
          state_nxt   = pend_r ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_nxt      = 8'h00;
          pend_nxt     = 1'b1;
          px_nxt       = {2'b00, in_x};
          col_nxt      = 3'd0;
          dx_nxt       = 3'd0;
          page_nxt     = in_pg_first;
          pg_first_nxt = in_pg_first;
          pg_last_nxt  = in_pg_last;
          y0_nxt       = in_y;
          sc_nxt       = in_sc;
          gidx_nxt     = gsel.idx;
          rd_ok_nxt    = idx_ok;
          case (in_op)
            sgfd_pkg::OP_CLEAR: state_nxt = S_CLEAR;
            sgfd_pkg::OP_DRAW:  state_nxt = draw_go ? S_DRAW : S_FINISH;
            sgfd_pkg::OP_READ:  state_nxt = S_READ;
            default:            state_nxt = S_FINISH;
          endcase
        end
      end
      S_DRAW: begin
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = draw_addr;
        wr_mask_nxt = mask;
        if (page_r == pg_last_r) begin
          page_nxt = pg_first_r;
          px_nxt   = px_r + 9'd1;
          if (dx_r == sc_r - 3'd1) begin
            dx_nxt  = 3'd0;
            col_nxt = col_r + 3'd1;
          end else begin
            dx_nxt = dx_r + 3'd1;
          end
          if (last_col) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          page_nxt = page_r + 4'd1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_READ: begin
        res_nxt   = rd_ok_r ? rd_data : 8'h00;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          pend_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pend_r      <= 1'b0;
      clr_cnt_r   <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    col_r      <= col_nxt;
    dx_r       <= dx_nxt;
    page_r     <= page_nxt;
    pg_first_r <= pg_first_nxt;
    pg_last_r  <= pg_last_nxt;
    y0_r       <= y0_nxt;
    sc_r       <= sc_nxt;
    gidx_r     <= gidx_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_r      <= res_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_mask_r  <= wr_mask_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_wr_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_DRAW || state_r == S_DRAIN))
    else $error("pending write-back outside a draw");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en && (rd_addr == wr_addr)))
    else $error("read and write of the same byte in one cycle");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_tready) |=> (state_r == S_FINISH))
    else $error("result overran an untaken output word");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("idle with a result still owed");

endmodule
